/* rtl/tmbc_pkg.sv */
// ----------------------------------------------------------------------------
// tmbc_pkg
// Shared constants, codes and helpers for the tile map box collision block.
// ----------------------------------------------------------------------------
package tmbc_pkg;

  // storage bounds (defaults for the top-level parameters)
  localparam int TMBC_MAX_COLUMNS = 64;
  localparam int TMBC_MAX_ROWS    = 64;

  // width that holds any map bound or compare limit (up to 1024)
  localparam int IDX_W = 11;

  // edge magnitude and divider sizes
  localparam int EDGE_W    = 18;
  localparam int MAG_W     = 16;
  localparam int DIV_W     = 8;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [1:0] REG_TILE_W   = 2'd0;
  localparam logic [1:0] REG_TILE_H   = 2'd1;
  localparam logic [1:0] REG_MAP_COLS = 2'd2;
  localparam logic [1:0] REG_MAP_ROWS = 2'd3;

  // configuration reset values
  localparam logic [7:0] TILE_W_RESET   = 8'd16;
  localparam logic [7:0] TILE_H_RESET   = 8'd16;
  localparam logic [6:0] MAP_COLS_RESET = 7'd64;
  localparam logic [6:0] MAP_ROWS_RESET = 7'd64;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // magnitude of a signed edge; always fits 16 bits for legal fields
  function automatic logic [MAG_W-1:0] edge_mag(input logic [EDGE_W-1:0] v);
    logic [EDGE_W-1:0] n;
    n = v[EDGE_W-1] ? (~v + EDGE_W'(1)) : v;
    return n[MAG_W-1:0];
  endfunction

  // a tile index is off the map if negative (nonzero after truncation)
  // or at or beyond the map size in use
  function automatic logic tile_off(input logic [MAG_W-1:0] q, input logic neg,
                                    input logic [IDX_W-1:0] limit);
    return (neg && (q != '0)) || (q >= {{(MAG_W-IDX_W){1'b0}}, limit});
  endfunction

endpackage

/* rtl/tmbc_ram.sv */
// ----------------------------------------------------------------------------
// tmbc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tmbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tmbc_div.sv */
// ----------------------------------------------------------------------------
// tmbc_div
// Restoring divider: 16-bit unsigned magnitude by 8-bit divisor, one
// quotient bit per step.
// ----------------------------------------------------------------------------
module tmbc_div
  import tmbc_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [MAG_W-1:0] quotient
);

  logic [DIV_W-1:0] dvsr;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem, quotient[MAG_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr};
    fits    = (rem_sh >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (step) begin
      rem      <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quotient <= {quotient[MAG_W-2:0], fits};
    end
  end

endmodule

/* rtl/tile_map_box_collision.sv */
// ----------------------------------------------------------------------------
// tile_map_box_collision
// One-bit tile collision map with cell writes and box corner queries.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears the map, one row per cycle.
// A cell write is a read-modify-write of one map row and then strobes done.
// A query runs four parallel bit-serial dividers that turn the box edges
// into tile indexes, then two reads of the single map read port for the top
// and bottom rows, and then strobes done.
// done is high for one cycle with blocked valid; it cannot be held off, so
// the receiver must take it then. Configuration is always ready and should
// only be written while busy is low.
// ----------------------------------------------------------------------------
module tile_map_box_collision
  import tmbc_pkg::*;
#(
  parameter int MAX_COLUMNS = TMBC_MAX_COLUMNS,
  parameter int MAX_ROWS    = TMBC_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [5:0]  cell_col,
  input  logic [5:0]  cell_row,
  input  logic        cell_blocked,
  input  logic [15:0] box_left,
  input  logic [15:0] box_top,
  input  logic [13:0] box_width,
  input  logic [13:0] box_height,
  // result
  output logic        done,
  output logic        blocked,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_WR     = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_RD_TOP = 3'd4;
  localparam logic [2:0] ST_RD_BOT = 3'd5;
  localparam logic [2:0] ST_RD_END = 3'd6;

  // configuration registers
  logic [7:0] tile_w;
  logic [7:0] tile_h;
  logic [6:0] map_cols;
  logic [6:0] map_rows;

  // control
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [ROW_W-1:0] clr_addr;
  logic [STEP_W-1:0] step_cnt;
  logic             accept;

  // pending write
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic             wr_bit;
  logic             wr_ok;

  // query edges
  logic [EDGE_W-1:0] left_ext;
  logic [EDGE_W-1:0] right_ext;
  logic [EDGE_W-1:0] top_ext;
  logic [EDGE_W-1:0] bot_ext;
  logic              lx_neg;
  logic              rx_neg;
  logic              ty_neg;
  logic              by_neg;
  logic [DIV_W-1:0]  div_w;
  logic [DIV_W-1:0]  div_h;
  logic [MAG_W-1:0]  lx_q;
  logic [MAG_W-1:0]  rx_q;
  logic [MAG_W-1:0]  ty_q;
  logic [MAG_W-1:0]  by_q;
  logic              div_step;

  // tile checks
  logic [IDX_W-1:0] cols_eff;
  logic [IDX_W-1:0] rows_eff;
  logic             lx_off;
  logic             rx_off;
  logic             ty_off;
  logic             by_off;
  logic [COL_W-1:0] lx_idx;
  logic [COL_W-1:0] rx_idx;
  logic             hit_top;
  logic             row_hit;

  // map memory
  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [MAX_COLUMNS-1:0] mem_wdata;
  logic                   mem_re;
  logic [ROW_W-1:0]       mem_raddr;
  logic [MAX_COLUMNS-1:0] mem_rdata;

  logic [IDX_W-1:0] cell_col_ext;
  logic [IDX_W-1:0] cell_row_ext;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_w   <= TILE_W_RESET;
      tile_h   <= TILE_H_RESET;
      map_cols <= MAP_COLS_RESET;
      map_rows <= MAP_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILE_W:   tile_w   <= cfg_data;
        REG_TILE_H:   tile_h   <= cfg_data;
        REG_MAP_COLS: map_cols <= cfg_data[6:0];
        REG_MAP_ROWS: map_rows <= cfg_data[6:0];
        default:      ;
      endcase
    end
  end

  // edges and divisors for a new query
  always_comb begin
    left_ext  = {{2{box_left[15]}}, box_left};
    top_ext   = {{2{box_top[15]}}, box_top};
    right_ext = left_ext + {4'b0, box_width} - EDGE_W'(1);
    bot_ext   = top_ext + {4'b0, box_height} - EDGE_W'(1);
    div_w     = (tile_w == '0) ? DIV_W'(1) : tile_w;
    div_h     = (tile_h == '0) ? DIV_W'(1) : tile_h;
    div_step  = (state == ST_DIV);
  end

  tmbc_div u_div_lx (
    .clk(clk), .load(accept), .step(div_step),
    .dividend(edge_mag(left_ext)), .divisor(div_w), .quotient(lx_q)
  );
  tmbc_div u_div_rx (
    .clk(clk), .load(accept), .step(div_step),
    .dividend(edge_mag(right_ext)), .divisor(div_w), .quotient(rx_q)
  );
  tmbc_div u_div_ty (
    .clk(clk), .load(accept), .step(div_step),
    .dividend(edge_mag(top_ext)), .divisor(div_h), .quotient(ty_q)
  );
  tmbc_div u_div_by (
    .clk(clk), .load(accept), .step(div_step),
    .dividend(edge_mag(bot_ext)), .divisor(div_h), .quotient(by_q)
  );

  // tile range checks against the saturated map size
  always_comb begin
    cols_eff = ({4'b0, map_cols} > IDX_W'(MAX_COLUMNS)) ? IDX_W'(MAX_COLUMNS)
                                                          : {4'b0, map_cols};
    rows_eff = ({4'b0, map_rows} > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS)
                                                       : {4'b0, map_rows};
    lx_off   = tile_off(lx_q, lx_neg, cols_eff);
    rx_off   = tile_off(rx_q, rx_neg, cols_eff);
    ty_off   = tile_off(ty_q, ty_neg, rows_eff);
    by_off   = tile_off(by_q, by_neg, rows_eff);
    lx_idx   = lx_q[COL_W-1:0];
    rx_idx   = rx_q[COL_W-1:0];
    row_hit  = lx_off || rx_off || mem_rdata[lx_idx] || mem_rdata[rx_idx];
    cell_col_ext = {5'b0, cell_col};
    cell_row_ext = {5'b0, cell_row};
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_row;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = cell_row_ext[ROW_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re = accept && (cmd == CMD_WRITE);
      end
      ST_WR: begin
        mem_we            = wr_ok;
        mem_wdata[wr_col] = wr_bit;
      end
      ST_RD_TOP: begin
        mem_re    = 1'b1;
        mem_raddr = ty_q[ROW_W-1:0];
      end
      ST_RD_BOT: begin
        mem_re    = 1'b1;
        mem_raddr = by_q[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  tmbc_ram #(
    .WIDTH(MAX_COLUMNS),
    .DEPTH(MAX_ROWS)
  ) u_map (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == ROW_W'(MAX_ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_next = (cmd == CMD_WRITE) ? ST_WR : ST_DIV;
      end
      ST_WR:     state_next = ST_IDLE;
      ST_DIV:    if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = ST_RD_TOP;
      ST_RD_TOP: state_next = ST_RD_BOT;
      ST_RD_BOT: state_next = ST_RD_END;
      ST_RD_END: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WR) || (state == ST_RD_END);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ROW_W'(1);
      end
      if (state == ST_DIV) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // item payload and result
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_row <= cell_row_ext[ROW_W-1:0];
      wr_col <= cell_col_ext[COL_W-1:0];
      wr_bit <= cell_blocked;
      wr_ok  <= (cell_col_ext < IDX_W'(MAX_COLUMNS)) &&
                (cell_row_ext < IDX_W'(MAX_ROWS));
      lx_neg <= left_ext[EDGE_W-1];
      rx_neg <= right_ext[EDGE_W-1];
      ty_neg <= top_ext[EDGE_W-1];
      by_neg <= bot_ext[EDGE_W-1];
    end
    // top row data is back in the bottom-read cycle
    if (state == ST_RD_BOT) begin
      hit_top <= ty_off || row_hit;
    end
    if (state == ST_WR) begin
      blocked <= 1'b0;
    end else if (state == ST_RD_END) begin
      blocked <= hit_top || by_off || row_hit;
    end
  end

endmodule
